// ----- hw/rtl/msgc_pkg.sv -----
// ---------------------------------------------------------------------------
// msgc_pkg
// Shared types and constants for the magnetometer sample gate.
// ---------------------------------------------------------------------------
`default_nettype none

package msgc_pkg;

   localparam int unsigned COUNT_WIDTH     = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam int unsigned NUM_AXES        = 3;
   localparam int unsigned NUM_OCTANTS     = 8;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_CLOSE = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SAMPLE_LIMIT = 4'd0,
      CSR_MIN_DISTANCE = 4'd1
   } csr_index_type;

   localparam logic [COUNT_WIDTH-1:0] SAMPLE_LIMIT_RESET = 16'hFFFF;

   function automatic logic [3:0] count_octants(input logic [NUM_OCTANTS-1:0] m);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < NUM_OCTANTS; i++) begin
         n = n + {3'b000, m[i]};
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/msgc_dist.sv -----
// ---------------------------------------------------------------------------
// msgc_dist
// Squared distance of a sample to the last accepted one, compared against
// the squared minimum distance.
// ---------------------------------------------------------------------------
`default_nettype none

module msgc_dist #(
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input  wire logic [2:0][SAMPLE_WIDTH-1:0] sample,
   input  wire logic [2:0][SAMPLE_WIDTH-1:0] last,
   input  wire logic [31:0]                  lim_sq,
   output      logic                         too_close
);
   import msgc_pkg::*;

   localparam int unsigned SQ_WIDTH  = 2 * SAMPLE_WIDTH;
   localparam int unsigned SUM_WIDTH = SQ_WIDTH + 2;
   localparam int unsigned CMP_WIDTH = (SUM_WIDTH > 32) ? SUM_WIDTH : 32;

   logic [2:0][SQ_WIDTH-1:0] sq;
   logic [SUM_WIDTH-1:0]     dist_sq;

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      logic [SAMPLE_WIDTH:0]   diff;
      logic [SAMPLE_WIDTH:0]   mag;
      assign diff = {sample[a][SAMPLE_WIDTH-1], sample[a]} - {last[a][SAMPLE_WIDTH-1], last[a]};
      assign mag  = diff[SAMPLE_WIDTH] ? (~diff + 1'b1) : diff;
      // |diff| never exceeds 2^W - 1, so the top bit of mag is always clear
      assign sq[a] = mag[SAMPLE_WIDTH-1:0] * mag[SAMPLE_WIDTH-1:0];
   end

   assign dist_sq = SUM_WIDTH'(sq[0]) + SUM_WIDTH'(sq[1]) + SUM_WIDTH'(sq[2]);
   assign too_close = CMP_WIDTH'(dist_sq) < CMP_WIDTH'(lim_sq);

endmodule

`default_nettype wire

// ----- hw/rtl/mag_sample_gate_and_coverage.sv -----
// ---------------------------------------------------------------------------
// mag_sample_gate_and_coverage
// Magnetometer calibration sample gate with octant coverage tracking.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one signed three-axis sample per transfer (valid/stall).
//   rsp_* returns exactly one result per sample: status, octant of the
//   sample, octant hit mask, number of octants hit and accepted count.
//   csr_* writes sample_limit (index 0) and min_distance (index 1); csr_ready
//   is always high. Write only while no sample is in flight. The squared
//   minimum distance is computed once at the write.
// Timing:
//   A sample is held in an input register; the gate, min/max update and
//   octant logic evaluate it combinationally and load the result register.
//   A transferred request passes the input register, then the result
//   register. Throughput is one sample per cycle while rsp_stall is low,
//   set by the single evaluation stage whose state update feeds the next
//   sample directly.
// Stall / reset:
//   When rsp_stall holds the result, the input register still takes one
//   more sample; req_stall rises only when both registers are occupied.
//   Synchronous reset clears counts, mask, min/max, last sample and
//   restores sample_limit = 65535, min_distance = 0.
// ---------------------------------------------------------------------------
`default_nettype none

module mag_sample_gate_and_coverage #(
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0]        req_sample_x,
   input  wire logic signed [SAMPLE_WIDTH-1:0]        req_sample_y,
   input  wire logic signed [SAMPLE_WIDTH-1:0]        req_sample_z,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      msgc_pkg::status_type                  rsp_status,
   output      logic [2:0]                            rsp_sample_octant,
   output      logic [7:0]                            rsp_hit_mask,
   output      logic [3:0]                            rsp_hit_octants,
   output      logic [msgc_pkg::COUNT_WIDTH-1:0]      rsp_sample_count,
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [msgc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [msgc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import msgc_pkg::*;

   // configuration
   logic [COUNT_WIDTH-1:0] sample_limit_ff;
   logic [31:0]            lim_sq_ff;

   // input register
   logic                          in_valid_ff;
   logic [2:0][SAMPLE_WIDTH-1:0]  in_sample_ff;

   // tracking state
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   logic [NUM_OCTANTS-1:0]        mask_ff, mask_in;
   logic [2:0][SAMPLE_WIDTH-1:0]  last_ff;
   logic [2:0][SAMPLE_WIDTH-1:0]  min_ff, min_in;
   logic [2:0][SAMPLE_WIDTH-1:0]  max_ff, max_in;

   // result register
   logic                          out_valid_ff;
   status_type                    status_ff, status_in;
   logic [2:0]                    octant_ff, octant_in;
   logic [NUM_OCTANTS-1:0]        hit_mask_ff;
   logic [3:0]                    hit_cnt_ff;
   logic [COUNT_WIDTH-1:0]        out_count_ff;

   logic advance;
   logic take_req;
   logic first;
   logic full;
   logic too_close;
   logic accept;
   logic [2:0] octant_calc;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_limit_ff <= SAMPLE_LIMIT_RESET;
         lim_sq_ff       <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SAMPLE_LIMIT: sample_limit_ff <= csr_wdata;
            CSR_MIN_DISTANCE: lim_sq_ff       <= csr_wdata * csr_wdata;
            default: ;
         endcase
      end
   end

   // the evaluation stage moves when the result register is free or drains
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take_req) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_sample_ff <= {req_sample_z, req_sample_y, req_sample_x};
      end
   end

   msgc_dist #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_dist (
      .sample    (in_sample_ff),
      .last      (last_ff),
      .lim_sq    (lim_sq_ff),
      .too_close (too_close)
   );

   assign first  = (count_ff == '0);
   assign full   = (count_ff >= sample_limit_ff);
   assign accept = !full && (first || !too_close);

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         if (first || ($signed(in_sample_ff[a]) < $signed(min_ff[a]))) begin
            min_in[a] = in_sample_ff[a];
         end else begin
            min_in[a] = min_ff[a];
         end
         if (first || ($signed(in_sample_ff[a]) > $signed(max_ff[a]))) begin
            max_in[a] = in_sample_ff[a];
         end else begin
            max_in[a] = max_ff[a];
         end
         // midpoint test without halving: 2*s > min + max
         octant_calc[a] = $signed({in_sample_ff[a], 1'b0}) >
                          $signed({min_in[a][SAMPLE_WIDTH-1], min_in[a]} +
                                  {max_in[a][SAMPLE_WIDTH-1], max_in[a]});
      end
   end

   always_comb begin
      if (full) begin
         status_in = ST_FULL;
      end else if (!accept) begin
         status_in = ST_CLOSE;
      end else begin
         status_in = ST_OK;
      end
      octant_in = accept ? octant_calc : 3'd0;
      mask_in   = accept ? (mask_ff | (NUM_OCTANTS'(1) << octant_calc)) : mask_ff;
      count_in  = accept ? (count_ff + 1'b1) : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mask_ff  <= '0;
         last_ff  <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
      end else if (advance && accept) begin
         count_ff <= count_in;
         mask_ff  <= mask_in;
         last_ff  <= in_sample_ff;
         min_ff   <= min_in;
         max_ff   <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff    <= status_in;
         octant_ff    <= octant_in;
         hit_mask_ff  <= mask_in;
         hit_cnt_ff   <= count_octants(mask_in);
         out_count_ff <= count_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_sample_octant = octant_ff;
   assign rsp_hit_mask      = hit_mask_ff;
   assign rsp_hit_octants   = hit_cnt_ff;
   assign rsp_sample_count  = out_count_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/msgc_checker.sv -----
// ---------------------------------------------------------------------------
// msgc_checker
// Port-level checks for the magnetometer sample gate, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module msgc_checker #(
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_valid,
   input wire logic                                  req_stall,
   input wire logic signed [SAMPLE_WIDTH-1:0]        req_sample_x,
   input wire logic signed [SAMPLE_WIDTH-1:0]        req_sample_y,
   input wire logic signed [SAMPLE_WIDTH-1:0]        req_sample_z,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_stall,
   input wire msgc_pkg::status_type                  rsp_status,
   input wire logic [2:0]                            rsp_sample_octant,
   input wire logic [7:0]                            rsp_hit_mask,
   input wire logic [3:0]                            rsp_hit_octants,
   input wire logic [msgc_pkg::COUNT_WIDTH-1:0]      rsp_sample_count,
   input wire logic                                  csr_valid,
   input wire logic                                  csr_ready,
   input wire logic [msgc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input wire logic [msgc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import msgc_pkg::*;

   // a held result keeps its hit mask, count and status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit_mask) &&
         $stable(rsp_sample_count) && $stable(rsp_status))
      else $error("result changed while stalled");

   a_refused_octant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_sample_octant == 3'd0)
      else $error("refused sample reports an octant");

   a_coverage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_octants == 4'($countones(rsp_hit_mask)))
      else $error("coverage count disagrees with hit mask");

   a_octant_marked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK) |-> rsp_hit_mask[rsp_sample_octant] &&
         (rsp_sample_count != '0))
      else $error("accepted sample not reflected in mask or count");

   a_mask_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sample_count == '0) |-> rsp_hit_mask == 8'd0)
      else $error("octant hit with no accepted sample");

endmodule

bind mag_sample_gate_and_coverage msgc_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_msgc_checker (.*);

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for mag_sample_gate_and_coverage: a local gate model
// predicts status, octant, hit mask, coverage and count for every sample
// transfer; results are compared in order. Sample limit and minimum distance
// are rewritten between phases while the block is drained.
// ---------------------------------------------------------------------------

module testbench;
   import msgc_pkg::*;

   localparam int unsigned SAMPLE_WIDTH   = 16;
   localparam int          HALF_PERIOD    = 10;
   localparam int          RESET_CYCLES   = 12;
   localparam int          WATCHDOG_LIMIT = 600;
   localparam int          LONG_HOLD      = 60;
   localparam int          HOLD_AFTER     = 400;
   localparam int          NUM_PHASES     = 14;
   localparam int          PHASE_ITEMS    = 74;
   localparam int          SETTLE_CYCLES  = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 4'd15;

   typedef struct {
      logic                             is_csr;
      logic [CSR_INDEX_WIDTH-1:0]       index;
      logic [CSR_DATA_WIDTH-1:0]        wdata;
      logic signed [SAMPLE_WIDTH-1:0]   x;
      logic signed [SAMPLE_WIDTH-1:0]   y;
      logic signed [SAMPLE_WIDTH-1:0]   z;
   } gate_op_type;

   typedef struct {
      status_type              status;
      logic [2:0]              octant;
      logic [7:0]              mask;
      logic [3:0]              octants;
      logic [COUNT_WIDTH-1:0]  count;
   } gate_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic signed [SAMPLE_WIDTH-1:0]     req_sample_x = '0;
   logic signed [SAMPLE_WIDTH-1:0]     req_sample_y = '0;
   logic signed [SAMPLE_WIDTH-1:0]     req_sample_z = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   status_type                         rsp_status;
   logic [2:0]                         rsp_sample_octant;
   logic [7:0]                         rsp_hit_mask;
   logic [3:0]                         rsp_hit_octants;
   logic [COUNT_WIDTH-1:0]             rsp_sample_count;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]         csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]          csr_wdata = '0;

   mag_sample_gate_and_coverage #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_x      (req_sample_x),
      .req_sample_y      (req_sample_y),
      .req_sample_z      (req_sample_z),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_sample_octant (rsp_sample_octant),
      .rsp_hit_mask      (rsp_hit_mask),
      .rsp_hit_octants   (rsp_hit_octants),
      .rsp_sample_count  (rsp_sample_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // gate model state, starts at its reset values
   int         gate_limit    = 65535;
   int         gate_min_dist = 0;
   int         gate_count    = 0;
   int         gate_last[3]  = '{0, 0, 0};
   int         axis_lo[3]    = '{0, 0, 0};
   int         axis_hi[3]    = '{0, 0, 0};
   logic [7:0] gate_mask     = '0;

   gate_op_type     pending[$];
   gate_result_type expected_results[$];

   logic req_took       = 1'b0;
   logic csr_took       = 1'b0;
   bit   quiet          = 1'b0;
   bit   long_hold_done = 1'b0;
   int   mismatches     = 0;
   int   results_seen   = 0;
   int   idle_cycles    = 0;
   int   send_gap       = 0;
   int   send_calm      = 0;
   int   recv_gap       = 0;
   int   recv_calm      = 0;
   int   hold_left      = 0;

   initial begin
      forever #(HALF_PERIOD) clock = ~clock;
   end

   function automatic gate_result_type predict_gate(input logic signed [SAMPLE_WIDTH-1:0] sx,
                                                    input logic signed [SAMPLE_WIDTH-1:0] sy,
                                                    input logic signed [SAMPLE_WIDTH-1:0] sz);
      gate_result_type res;
      int              s[3];
      longint          d;
      longint          dist2;
      longint          lim2;
      s[0] = int'(sx);
      s[1] = int'(sy);
      s[2] = int'(sz);
      res.status = ST_OK;
      res.octant = '0;
      if (gate_count >= gate_limit) begin
         res.status = ST_FULL;
      end else if (gate_count != 0) begin
         dist2 = 0;
         for (int i = 0; i < 3; i++) begin
            d = longint'(s[i]) - longint'(gate_last[i]);
            dist2 += d * d;
         end
         lim2 = longint'(gate_min_dist) * longint'(gate_min_dist);
         if (dist2 < lim2) res.status = ST_CLOSE;
      end
      if (res.status == ST_OK) begin
         for (int i = 0; i < 3; i++) begin
            if (gate_count == 0 || s[i] < axis_lo[i]) axis_lo[i] = s[i];
            if (gate_count == 0 || s[i] > axis_hi[i]) axis_hi[i] = s[i];
            gate_last[i] = s[i];
         end
         // midpoint test without halving
         for (int i = 0; i < 3; i++) begin
            if (2 * s[i] > axis_lo[i] + axis_hi[i]) res.octant[i] = 1'b1;
         end
         gate_mask[res.octant] = 1'b1;
         gate_count = gate_count + 1;
      end
      res.mask    = gate_mask;
      res.octants = 4'($countones(gate_mask));
      res.count   = gate_count[COUNT_WIDTH-1:0];
      return res;
   endfunction

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // transfers on all three channels, model update and result checking
   always @(posedge clock) begin : observe
      gate_result_type want;
      logic            moved;
      req_took <= req_valid && !req_stall;
      csr_took <= csr_valid && csr_ready;
      moved = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            if (csr_index == CSR_SAMPLE_LIMIT) gate_limit = int'(csr_wdata);
            else if (csr_index == CSR_MIN_DISTANCE) gate_min_dist = int'(csr_wdata);
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            expected_results.push_back(predict_gate(req_sample_x, req_sample_y, req_sample_z));
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            results_seen++;
            if (expected_results.size() == 0) begin
               $display("%0t: result transfer with no sample outstanding", $time);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", longint'(want.status), longint'(rsp_status));
               check_field("sample_octant", longint'(want.octant),
                           longint'(rsp_sample_octant));
               check_field("hit_mask", longint'(want.mask), longint'(rsp_hit_mask));
               check_field("hit_octants", longint'(want.octants),
                           longint'(rsp_hit_octants));
               check_field("sample_count", longint'(want.count),
                           longint'(rsp_sample_count));
            end
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
      end
   end

   always @(posedge clock) begin : watchdog
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("mag_sample_gate_and_coverage regression: fail");
         $finish;
      end
   end

   // sender: one op per transfer, idle bursts only between transfers
   always @(negedge clock) begin : drive_req
      gate_op_type op;
      logic        nxt_valid;
      logic        nxt_csr;
      nxt_valid = req_valid;
      nxt_csr   = csr_valid;
      if (!reset) begin
         if (req_valid && req_took) nxt_valid = 1'b0;
         if (csr_valid && csr_took) nxt_csr = 1'b0;
         if (send_calm != 0) send_calm--;
         if (send_gap != 0) begin
            send_gap--;
         end else if (!nxt_valid && !nxt_csr && pending.size() != 0) begin
            if (!quiet && send_calm == 0 && $urandom_range(0, 4) == 0) begin
               send_gap = $urandom_range(0, 6);
            end else begin
               if (!quiet && send_calm == 0 && $urandom_range(0, 19) == 0)
                  send_calm = $urandom_range(10, 60);
               op = pending.pop_front();
               if (op.is_csr) begin
                  nxt_csr = 1'b1;
                  csr_index <= op.index;
                  csr_wdata <= op.wdata;
               end else begin
                  nxt_valid = 1'b1;
                  req_sample_x <= op.x;
                  req_sample_y <= op.y;
                  req_sample_z <= op.z;
               end
            end
         end
      end
      req_valid <= nxt_valid;
      csr_valid <= nxt_csr;
   end

   // receiver: random stall bursts plus one long hold while samples keep coming
   always @(negedge clock) begin : drive_rsp
      logic hold;
      hold = 1'b0;
      if (recv_calm != 0) recv_calm--;
      if (hold_left != 0) begin
         hold_left--;
         hold = 1'b1;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER && pending.size() > 20) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         hold = 1'b1;
      end else if (quiet) begin
         hold = 1'b0;
      end else if (recv_gap != 0) begin
         recv_gap--;
         hold = 1'b1;
      end else if (recv_calm == 0) begin
         case ($urandom_range(0, 9))
            0: begin
               recv_gap = $urandom_range(0, 6);
               hold = 1'b1;
            end
            1: recv_calm = $urandom_range(10, 60);
            default: ;
         endcase
      end
      rsp_stall <= hold;
   end

   task automatic push_sample(input int x, input int y, input int z);
      gate_op_type op;
      op.is_csr = 1'b0;
      op.index  = '0;
      op.wdata  = '0;
      op.x      = x[SAMPLE_WIDTH-1:0];
      op.y      = y[SAMPLE_WIDTH-1:0];
      op.z      = z[SAMPLE_WIDTH-1:0];
      pending.push_back(op);
   endtask

   task automatic push_csr(input logic [CSR_INDEX_WIDTH-1:0] index, input int value);
      gate_op_type op;
      op.is_csr = 1'b1;
      op.index  = index;
      op.wdata  = value[CSR_DATA_WIDTH-1:0];
      op.x      = '0;
      op.y      = '0;
      op.z      = '0;
      pending.push_back(op);
   endtask

   // every queued op transferred and every result back, then a settling wait
   task automatic wait_drained();
      while (pending.size() != 0 || req_valid || csr_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      logic signed [SAMPLE_WIDTH-1:0] walk[3];
      int extremes[4];
      int lim;
      int mind;
      int spread;
      int step;
      extremes = '{-32768, -1, 0, 32767};
      walk = '{default: '0};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill to a limit of four: first sample, extremes, then full
      push_csr(CSR_SAMPLE_LIMIT, 4);
      push_csr(CSR_MIN_DISTANCE, 0);
      push_sample(-32768, 32767, -32768);
      push_sample(32767, -32768, 32767);
      push_sample(0, 0, 0);
      push_sample(-1, -1, -1);
      push_sample(100, -100, 5);
      wait_drained();
      // full and too close at once: full wins
      push_csr(CSR_MIN_DISTANCE, 65535);
      push_sample(32767, 32767, 32767);
      wait_drained();
      push_csr(CSR_SAMPLE_LIMIT, 65535);
      push_csr(CSR_UNUSED_INDEX, 0);
      push_sample(32767, 32767, 32767);
      push_sample(-32768, -32768, -32768);
      wait_drained();
      // distance exactly at the minimum passes, just below is refused
      push_csr(CSR_MIN_DISTANCE, 10);
      push_sample(-1, -1, 9);
      push_sample(-1, -1, 0);
      push_sample(2, 5, 9);
      push_sample(-1, -1, -1);
      push_sample(32767, -32768, 0);
      wait_drained();
      push_csr(CSR_SAMPLE_LIMIT, 0);
      push_sample(1, 2, 3);
      push_sample(-32768, -32768, -32768);
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         lim = 65535;
         case ($urandom_range(0, 3))
            0: mind = 0;
            1: mind = $urandom_range(1, 8);
            2: mind = $urandom_range(9, 300);
            default: mind = $urandom_range(301, 5000);
         endcase
         if (p == 2) begin
            lim = (gate_count + 25 > 65535) ? 65535 : gate_count + 25;
         end else if (p == 4) begin
            lim = 0;
         end else if (p == 7) begin
            mind = 65535;
         end else if (p == NUM_PHASES - 1) begin
            mind = 0;
            quiet = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            lim = $urandom_range(gate_count + 40, 65535);
         end
         push_csr(CSR_SAMPLE_LIMIT, lim);
         push_csr(CSR_MIN_DISTANCE, mind);
         spread = mind + mind / 2 + 2;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  // short random walk, lands on both sides of the distance bound
                  for (int i = 0; i < 3; i++) begin
                     step = int'($urandom_range(0, 2 * spread)) - spread;
                     walk[i] = walk[i] + step[SAMPLE_WIDTH-1:0];
                  end
               end
               5, 6, 7: begin
                  for (int i = 0; i < 3; i++) walk[i] = SAMPLE_WIDTH'($urandom);
               end
               8: begin
                  for (int i = 0; i < 3; i++)
                     walk[i] = SAMPLE_WIDTH'(extremes[$urandom_range(0, 3)]);
               end
               default: ;
            endcase
            push_sample(int'(walk[0]), int'(walk[1]), int'(walk[2]));
         end
         wait_drained();
      end

      if (mismatches == 0) begin
         $display("mag_sample_gate_and_coverage regression: pass");
      end else begin
         $display("mag_sample_gate_and_coverage regression: fail");
      end
      $finish;
   end

endmodule

// ----- mag_sample_gate_and_coverage.f -----
hw/rtl/msgc_pkg.sv
hw/rtl/msgc_dist.sv
hw/rtl/mag_sample_gate_and_coverage.sv
hw/rtl/msgc_checker.sv
dv/testbench.sv
